// ===== hw/rtl/cmdfd_pkg.sv =====
// Shared types and constants of the command frame deframer.
package cmdfd_pkg;

   localparam int QUEUE_DEPTH = 4;
   localparam int MAX_LIMIT = 240;

   typedef enum logic [1:0] {
      CSR_HEADER_PATTERN = 2'd0,
      CSR_TAIL_PATTERN   = 2'd1,
      CSR_MAX_PAYLOAD    = 2'd2,
      CSR_UNUSED         = 2'd3
   } csr_index_type;

   typedef enum logic [1:0] {
      STATUS_OK         = 2'd0,
      STATUS_CHECKSUM   = 2'd1,
      STATUS_TAIL       = 2'd2,
      STATUS_BAD_LENGTH = 2'd3
   } status_type;

   typedef struct packed {
      logic        enable;
      logic [1:0]  index;
      logic [31:0] data;
   } csr_write_type;

   typedef struct packed {
      logic        is_end;
      status_type  status;
      logic [7:0]  command;
      logic [7:0]  data_byte;
      logic [7:0]  index;
      logic [7:0]  count;
   } record_type;

endpackage

// ===== hw/rtl/cmdfd_parser.sv =====
// Front end: byte-at-a-time frame parser that classifies bytes into result records.
module cmdfd_parser #(
   parameter int HEADER_BYTES = 4,
   parameter int TAIL_BYTES = 2
) (
   input  logic                   clock,
   input  logic                   reset,
   input  cmdfd_pkg::csr_write_type csr,
   input  logic                   in_push,
   input  logic [7:0]             in_byte,
   input  logic                   queue_full,
   output logic                   rec_push,
   output cmdfd_pkg::record_type  rec
);
   import cmdfd_pkg::*;

   typedef enum logic [7:0] {
      PHASE_HUNT   = 8'b0000_0001,
      PHASE_LEN_LO = 8'b0000_0010,
      PHASE_LEN_HI = 8'b0000_0100,
      PHASE_CMD    = 8'b0000_1000,
      PHASE_DATA   = 8'b0001_0000,
      PHASE_SUM_LO = 8'b0010_0000,
      PHASE_SUM_HI = 8'b0100_0000,
      PHASE_TAIL   = 8'b1000_0000
   } phase_type;

   logic [31:0] header_ff, header_in;
   logic [15:0] tail_pattern_ff, tail_pattern_in;
   logic [7:0]  max_payload_ff, max_payload_in;

   phase_type   phase_ff, phase_in;
   logic [2:0]  matched_ff, matched_in;
   logic [7:0]  len_lo_ff, len_lo_in;
   logic [7:0]  total_ff, total_in;
   logic [7:0]  remaining_ff, remaining_in;
   logic [15:0] sum_ff, sum_in;
   logic [7:0]  command_ff, command_in;
   logic [15:0] rx_sum_ff, rx_sum_in;
   logic        tail_ok_ff, tail_ok_in;
   logic        tail_count_ff, tail_count_in;

   logic        accept;
   logic [7:0]  limit;
   logic [15:0] frame_length;
   logic [16:0] data_wide;
   logic [2:0]  hunt_next;
   logic [7:0]  tail_want;
   logic        tail_good;
   logic        tail_last;

   assign accept = in_push && !queue_full;
   assign limit = (max_payload_ff > 8'(MAX_LIMIT)) ? 8'(MAX_LIMIT) : max_payload_ff;
   assign frame_length = {in_byte, len_lo_ff};
   assign data_wide = {1'b0, frame_length} - 17'd3;
   assign tail_want = tail_count_ff ? tail_pattern_ff[15:8] : tail_pattern_ff[7:0];
   assign tail_last = (TAIL_BYTES == 1) || tail_count_ff;

   always_comb begin
      if (in_byte == header_ff[8 * matched_ff[1:0] +: 8]) begin
         hunt_next = matched_ff + 3'd1;
      end else if (in_byte == header_ff[7:0]) begin
         hunt_next = 3'd1;
      end else begin
         hunt_next = 3'd0;
      end
   end

   always_comb begin
      header_in = header_ff;
      tail_pattern_in = tail_pattern_ff;
      max_payload_in = max_payload_ff;
      if (csr.enable) begin
         case (csr.index)
            CSR_HEADER_PATTERN: header_in = csr.data;
            CSR_TAIL_PATTERN:   tail_pattern_in = csr.data[15:0];
            CSR_MAX_PAYLOAD:    max_payload_in = csr.data[7:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      phase_in = phase_ff;
      matched_in = matched_ff;
      len_lo_in = len_lo_ff;
      total_in = total_ff;
      remaining_in = remaining_ff;
      sum_in = sum_ff;
      command_in = command_ff;
      rx_sum_in = rx_sum_ff;
      tail_ok_in = tail_ok_ff;
      tail_count_in = tail_count_ff;
      tail_good = 1'b0;
      rec_push = 1'b0;
      rec.is_end = 1'b0;
      rec.status = STATUS_OK;
      rec.command = command_ff;
      rec.data_byte = in_byte;
      rec.index = total_ff - remaining_ff;
      rec.count = total_ff;
      if (accept) begin
         case (phase_ff)
            PHASE_HUNT: begin
               if (hunt_next >= 3'(HEADER_BYTES)) begin
                  matched_in = 3'd0;
                  phase_in = PHASE_LEN_LO;
               end else begin
                  matched_in = hunt_next;
               end
            end
            PHASE_LEN_LO: begin
               len_lo_in = in_byte;
               sum_in = {8'd0, in_byte};
               phase_in = PHASE_LEN_HI;
            end
            PHASE_LEN_HI: begin
               sum_in = sum_ff + {8'd0, in_byte};
               if (frame_length < 16'd3 || data_wide > {9'd0, limit}) begin
                  phase_in = PHASE_HUNT;
                  matched_in = 3'd0;
                  rec_push = 1'b1;
                  rec.is_end = 1'b1;
                  rec.status = STATUS_BAD_LENGTH;
               end else begin
                  total_in = data_wide[7:0];
                  remaining_in = data_wide[7:0];
                  phase_in = PHASE_CMD;
               end
            end
            PHASE_CMD: begin
               command_in = in_byte;
               sum_in = sum_ff + {8'd0, in_byte};
               phase_in = (remaining_ff != 8'd0) ? PHASE_DATA : PHASE_SUM_LO;
            end
            PHASE_DATA: begin
               sum_in = sum_ff + {8'd0, in_byte};
               remaining_in = remaining_ff - 8'd1;
               if (remaining_ff == 8'd1) begin
                  phase_in = PHASE_SUM_LO;
               end
               rec_push = 1'b1;
            end
            PHASE_SUM_LO: begin
               rx_sum_in = {8'd0, in_byte};
               phase_in = PHASE_SUM_HI;
            end
            PHASE_SUM_HI: begin
               rx_sum_in = {in_byte, rx_sum_ff[7:0]};
               phase_in = PHASE_TAIL;
               tail_ok_in = 1'b0;
               tail_count_in = 1'b0;
            end
            PHASE_TAIL: begin
               if (!tail_count_ff) begin
                  tail_good = (in_byte == tail_want);
                  tail_ok_in = tail_good;
               end else begin
                  tail_good = tail_ok_ff && (in_byte == tail_want);
               end
               if (tail_last) begin
                  tail_count_in = 1'b0;
                  phase_in = PHASE_HUNT;
                  matched_in = 3'd0;
                  rec_push = 1'b1;
                  rec.is_end = 1'b1;
                  if (!tail_good) begin
                     rec.status = STATUS_TAIL;
                  end else if (sum_ff != rx_sum_ff) begin
                     rec.status = STATUS_CHECKSUM;
                  end else begin
                     rec.status = STATUS_OK;
                  end
               end else begin
                  tail_count_in = 1'b1;
               end
            end
            default: begin
               phase_in = PHASE_HUNT;
               matched_in = 3'd0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         header_ff <= '0;
         tail_pattern_ff <= '0;
         max_payload_ff <= 8'(MAX_LIMIT);
         phase_ff <= PHASE_HUNT;
         matched_ff <= '0;
         len_lo_ff <= '0;
         total_ff <= '0;
         remaining_ff <= '0;
         sum_ff <= '0;
         command_ff <= '0;
         rx_sum_ff <= '0;
         tail_ok_ff <= 1'b0;
         tail_count_ff <= 1'b0;
      end else begin
         header_ff <= header_in;
         tail_pattern_ff <= tail_pattern_in;
         max_payload_ff <= max_payload_in;
         phase_ff <= phase_in;
         matched_ff <= matched_in;
         len_lo_ff <= len_lo_in;
         total_ff <= total_in;
         remaining_ff <= remaining_in;
         sum_ff <= sum_in;
         command_ff <= command_in;
         rx_sum_ff <= rx_sum_in;
         tail_ok_ff <= tail_ok_in;
         tail_count_ff <= tail_count_in;
      end
   end

   a_end_returns_to_hunt: assert property (@(posedge clock) disable iff (reset)
      rec_push && rec.is_end |=> phase_ff == PHASE_HUNT)
      else $error("end record pushed without returning to the header hunt");

   a_data_has_bytes_due: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PHASE_DATA |-> remaining_ff != 8'd0)
      else $error("data phase entered with no data bytes due");

   a_index_within_count: assert property (@(posedge clock) disable iff (reset)
      rec_push && !rec.is_end |-> rec.index < rec.count)
      else $error("payload index beyond the frame data count");

   a_matched_below_header: assert property (@(posedge clock) disable iff (reset)
      matched_ff < 3'(HEADER_BYTES))
      else $error("header match count reached the header length");

endmodule

// ===== hw/rtl/cmdfd_queue.sv =====
// Short record queue between the parser front end and the result back end.
module cmdfd_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  cmdfd_pkg::record_type push_rec,
   output logic                  full,
   input  logic                  pop,
   output logic                  empty,
   output cmdfd_pkg::record_type head_rec
);
   import cmdfd_pkg::*;

   localparam int PTR_BITS = $clog2(QUEUE_DEPTH);
   localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);

   record_type           mem [QUEUE_DEPTH];
   logic [PTR_BITS-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_BITS-1:0]  count_ff, count_in;
   logic                 do_push;
   logic                 do_pop;

   assign full = (count_ff == CNT_BITS'(QUEUE_DEPTH));
   assign empty = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop = pop && !empty;
   assign head_rec = mem[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem[wr_ptr_ff] <= push_rec;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   a_count_bounded: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_BITS'(QUEUE_DEPTH))
      else $error("queue occupancy above its depth");

   a_push_only_with_room: assert property (@(posedge clock) disable iff (reset)
      push |-> !full)
      else $error("request pushed into a full queue");

   a_pop_alone_drains: assert property (@(posedge clock) disable iff (reset)
      do_pop && !do_push |=> count_ff == $past(count_ff) - 1'b1)
      else $error("queue occupancy did not fall after a pop");

endmodule

// ===== hw/rtl/cmdfd_format.sv =====
// Back end: turns the oldest queued record into the result fields.
module cmdfd_format (
   input  cmdfd_pkg::record_type rec,
   output logic [7:0]            command_code,
   output logic [7:0]            payload_byte,
   output logic [7:0]            payload_index,
   output logic [7:0]            data_count,
   output logic                  is_end,
   output logic [1:0]            frame_status
);
   import cmdfd_pkg::*;

   logic bad_length;

   assign bad_length = rec.is_end && (rec.status == STATUS_BAD_LENGTH);
   assign is_end = rec.is_end;
   assign frame_status = rec.is_end ? rec.status : STATUS_OK;
   assign command_code = bad_length ? 8'd0 : rec.command;
   assign data_count = bad_length ? 8'd0 : rec.count;
   assign payload_byte = rec.is_end ? 8'd0 : rec.data_byte;
   assign payload_index = rec.is_end ? 8'd0 : rec.index;

endmodule

// ===== hw/rtl/command_frame_deframer.sv =====
// Top level of the command frame deframer: parser, record queue and result formatter.
// The deframer takes one received byte per clock while req_full is low and gives
// at most one result per byte: a data result for every payload byte and one end
// result with the frame status after the last tail byte, or at once on a bad length.
// Results pass through a four-entry queue, so bytes are taken while earlier results
// wait to be popped; req_full rises only while that queue holds four waiting results.
// A result can be popped in the cycle after the byte that caused it is taken.
// Configuration writes take effect at the next clock edge and are meant for when no frame is in progress.
module command_frame_deframer #(
   parameter int HEADER_BYTES = 4,
   parameter int TAIL_BYTES = 2
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   output logic        req_full,
   input  logic [7:0]  req_rx_byte,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic [7:0]  rsp_command_code,
   output logic [7:0]  rsp_payload_byte,
   output logic [7:0]  rsp_payload_index,
   output logic [7:0]  rsp_data_count,
   output logic        rsp_is_end,
   output logic [1:0]  rsp_frame_status,
   input  logic        csr_write_enable,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_write_data
);
   import cmdfd_pkg::*;

   csr_write_type csr;
   record_type    push_rec;
   record_type    head_rec;
   logic          rec_push;

   assign csr.enable = csr_write_enable;
   assign csr.index = csr_index;
   assign csr.data = csr_write_data;

   cmdfd_parser #(
      .HEADER_BYTES(HEADER_BYTES),
      .TAIL_BYTES(TAIL_BYTES)
   ) u_parser (
      .clock(clock),
      .reset(reset),
      .csr(csr),
      .in_push(req_push),
      .in_byte(req_rx_byte),
      .queue_full(req_full),
      .rec_push(rec_push),
      .rec(push_rec)
   );

   cmdfd_queue u_queue (
      .clock(clock),
      .reset(reset),
      .push(rec_push),
      .push_rec(push_rec),
      .full(req_full),
      .pop(rsp_pop),
      .empty(rsp_empty),
      .head_rec(head_rec)
   );

   cmdfd_format u_format (
      .rec(head_rec),
      .command_code(rsp_command_code),
      .payload_byte(rsp_payload_byte),
      .payload_index(rsp_payload_index),
      .data_count(rsp_data_count),
      .is_end(rsp_is_end),
      .frame_status(rsp_frame_status)
   );

endmodule

// ===== tb/command_frame_deframer_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench of the command frame deframer with a predicting scoreboard.

module command_frame_deframer_tb;
   import cmdfd_pkg::*;

   localparam int FRAME_HEADER_BYTES = 4;
   localparam int FRAME_TAIL_BYTES = 2;
   localparam int LATENCY_CYCLES = 4;

   typedef enum logic [2:0] {
      PARSE_HUNT,
      PARSE_LEN_LO,
      PARSE_LEN_HI,
      PARSE_COMMAND,
      PARSE_DATA,
      PARSE_SUM_LO,
      PARSE_SUM_HI,
      PARSE_TAIL
   } parse_phase_type;

   typedef enum int {
      FRAME_GOOD,
      FRAME_BAD_SUM,
      FRAME_BAD_TAIL,
      FRAME_BAD_BOTH,
      FRAME_SHORT_LENGTH,
      FRAME_LONG_LENGTH
   } frame_kind_type;

   class deframe_scoreboard;
      logic [31:0] header_pattern = '0;
      logic [15:0] tail_pattern = '0;
      logic [7:0] max_payload = 8'd240;
      parse_phase_type phase = PARSE_HUNT;
      int unsigned header_matched = 0;
      logic [7:0] length_low = '0;
      logic [15:0] frame_length = '0;
      logic [7:0] bytes_left = '0;
      logic [15:0] running_sum = '0;
      logic [7:0] command = '0;
      logic [15:0] received_sum = '0;
      bit tail_first_ok = 1'b0;
      record_type due_records[$];
      int unsigned failures = 0;

      function int payload_limit();
         return (max_payload > MAX_LIMIT) ? MAX_LIMIT : int'(max_payload);
      endfunction

      function logic [7:0] data_total();
         return 8'(frame_length - 16'd3);
      endfunction

      function int unsigned pending();
         return due_records.size();
      endfunction

      function void write_register(csr_index_type index, logic [31:0] value);
         case (index)
            CSR_HEADER_PATTERN: header_pattern = value;
            CSR_TAIL_PATTERN: tail_pattern = value[15:0];
            CSR_MAX_PAYLOAD: max_payload = value[7:0];
            default: ;
         endcase
      endfunction

      function void add_result(logic is_end, status_type status, logic [7:0] cmd,
                               logic [7:0] data_byte, logic [7:0] index, logic [7:0] count);
         record_type rec;
         rec.is_end = is_end;
         rec.status = status;
         rec.command = cmd;
         rec.data_byte = data_byte;
         rec.index = index;
         rec.count = count;
         due_records.push_back(rec);
      endfunction

      function void note_byte(logic [7:0] b);
         logic [7:0] want;
         bit ok;
         status_type status;
         case (phase)
            PARSE_HUNT: begin
               if (b == header_pattern[8*header_matched +: 8]) begin
                  header_matched++;
               end else if (b == header_pattern[7:0]) begin
                  header_matched = 1;
               end else begin
                  header_matched = 0;
               end
               if (header_matched >= FRAME_HEADER_BYTES) begin
                  header_matched = 0;
                  phase = PARSE_LEN_LO;
               end
            end
            PARSE_LEN_LO: begin
               length_low = b;
               running_sum = 16'(b);
               phase = PARSE_LEN_HI;
            end
            PARSE_LEN_HI: begin
               frame_length = {b, length_low};
               running_sum = running_sum + 16'(b);
               if (frame_length < 16'd3 || int'(frame_length) - 3 > payload_limit()) begin
                  phase = PARSE_HUNT;
                  header_matched = 0;
                  add_result(1'b1, STATUS_BAD_LENGTH, '0, '0, '0, '0);
               end else begin
                  bytes_left = data_total();
                  phase = PARSE_COMMAND;
               end
            end
            PARSE_COMMAND: begin
               command = b;
               running_sum = running_sum + 16'(b);
               phase = (bytes_left != 0) ? PARSE_DATA : PARSE_SUM_LO;
            end
            PARSE_DATA: begin
               add_result(1'b0, STATUS_OK, command, b, data_total() - bytes_left, data_total());
               running_sum = running_sum + 16'(b);
               if (bytes_left != 0) bytes_left--;
               if (bytes_left == 0) phase = PARSE_SUM_LO;
            end
            PARSE_SUM_LO: begin
               received_sum = 16'(b);
               phase = PARSE_SUM_HI;
            end
            PARSE_SUM_HI: begin
               received_sum[15:8] = b;
               phase = PARSE_TAIL;
               bytes_left = '0;
               tail_first_ok = 1'b0;
            end
            default: begin
               want = (bytes_left != 0) ? tail_pattern[15:8] : tail_pattern[7:0];
               if (bytes_left == 0) begin
                  tail_first_ok = (b == want);
                  ok = tail_first_ok;
               end else begin
                  ok = tail_first_ok && (b == want);
               end
               bytes_left++;
               if (bytes_left >= FRAME_TAIL_BYTES) begin
                  bytes_left = '0;
                  phase = PARSE_HUNT;
                  header_matched = 0;
                  if (!ok) status = STATUS_TAIL;
                  else if (running_sum != received_sum) status = STATUS_CHECKSUM;
                  else status = STATUS_OK;
                  add_result(1'b1, status, command, '0, '0, data_total());
               end
            end
         endcase
      endfunction

      function void compare_field(string name, logic [7:0] want, logic [7:0] got);
         if (got !== want) begin
            failures++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
         end
      endfunction

      function void check_result(record_type got);
         record_type want;
         if (due_records.size() == 0) begin
            failures++;
            $display("%0t: result with nothing expected, actual end %0b status %0d command %0h",
                     $time, got.is_end, got.status, got.command);
            return;
         end
         want = due_records.pop_front();
         compare_field("is_end", 8'(want.is_end), 8'(got.is_end));
         compare_field("frame_status", 8'(want.status), 8'(got.status));
         compare_field("command_code", want.command, got.command);
         compare_field("payload_byte", want.data_byte, got.data_byte);
         compare_field("payload_index", want.index, got.index);
         compare_field("data_count", want.count, got.count);
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_push = 1'b0;
   logic        req_full;
   logic [7:0]  req_rx_byte = '0;
   logic        rsp_empty;
   logic        rsp_pop = 1'b0;
   logic [7:0]  rsp_command_code;
   logic [7:0]  rsp_payload_byte;
   logic [7:0]  rsp_payload_index;
   logic [7:0]  rsp_data_count;
   logic        rsp_is_end;
   logic [1:0]  rsp_frame_status;
   logic        csr_write_enable = 1'b0;
   logic [1:0]  csr_index = '0;
   logic [31:0] csr_write_data = '0;

   int unsigned send_idle_pct = 0;
   int unsigned recv_idle_pct = 0;
   int unsigned frame_items = 0;

   deframe_scoreboard scoreboard = new();

   command_frame_deframer dut (
      .clock(clock),
      .reset(reset),
      .req_push(req_push),
      .req_full(req_full),
      .req_rx_byte(req_rx_byte),
      .rsp_empty(rsp_empty),
      .rsp_pop(rsp_pop),
      .rsp_command_code(rsp_command_code),
      .rsp_payload_byte(rsp_payload_byte),
      .rsp_payload_index(rsp_payload_index),
      .rsp_data_count(rsp_data_count),
      .rsp_is_end(rsp_is_end),
      .rsp_frame_status(rsp_frame_status),
      .csr_write_enable(csr_write_enable),
      .csr_index(csr_index),
      .csr_write_data(csr_write_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(negedge clock) begin
      rsp_pop <= ($urandom_range(0, 99) >= recv_idle_pct);
   end

   always @(posedge clock) begin
      record_type got;
      if (!reset && rsp_pop && !rsp_empty) begin
         got.is_end = rsp_is_end;
         got.status = status_type'(rsp_frame_status);
         got.command = rsp_command_code;
         got.data_byte = rsp_payload_byte;
         got.index = rsp_payload_index;
         got.count = rsp_data_count;
         scoreboard.check_result(got);
      end
   end

   task automatic send_byte(input logic [7:0] value);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_push <= 1'b0;
         @(negedge clock);
      end
      req_push <= 1'b1;
      req_rx_byte <= value;
      do begin
         @(posedge clock);
      end while (req_full);
      scoreboard.note_byte(value);
      @(negedge clock);
   endtask

   task automatic send_frame(input logic [7:0] cmd, input int count, input frame_kind_type kind);
      logic [7:0] frame_bytes[$];
      logic [15:0] length;
      logic [15:0] sum;
      logic [15:0] tail;
      logic [7:0] value;
      int limit;
      limit = scoreboard.payload_limit();
      for (int i = 0; i < FRAME_HEADER_BYTES; i++) begin
         frame_bytes.push_back(scoreboard.header_pattern[8*i +: 8]);
      end
      case (kind)
         FRAME_SHORT_LENGTH: length = 16'($urandom_range(0, 2));
         FRAME_LONG_LENGTH: begin
            if ($urandom_range(0, 1) != 0) length = 16'(limit + 4 + $urandom_range(0, 16));
            else length = 16'($urandom_range(256, 65535));
         end
         default: length = 16'(count + 3);
      endcase
      frame_bytes.push_back(length[7:0]);
      frame_bytes.push_back(length[15:8]);
      if (kind != FRAME_SHORT_LENGTH && kind != FRAME_LONG_LENGTH) begin
         sum = 16'(length[7:0]) + 16'(length[15:8]) + 16'(cmd);
         frame_bytes.push_back(cmd);
         for (int i = 0; i < count; i++) begin
            value = 8'($urandom);
            frame_bytes.push_back(value);
            sum = sum + 16'(value);
         end
         if (kind == FRAME_BAD_SUM || kind == FRAME_BAD_BOTH) begin
            sum = sum ^ 16'($urandom_range(1, 65535));
         end
         frame_bytes.push_back(sum[7:0]);
         frame_bytes.push_back(sum[15:8]);
         tail = scoreboard.tail_pattern;
         if (kind == FRAME_BAD_TAIL || kind == FRAME_BAD_BOTH) begin
            tail = tail ^ 16'($urandom_range(1, 65535));
         end
         frame_bytes.push_back(tail[7:0]);
         frame_bytes.push_back(tail[15:8]);
      end
      frame_items += frame_bytes.size();
      foreach (frame_bytes[i]) send_byte(frame_bytes[i]);
   endtask

   task automatic send_false_start();
      int depth;
      logic [7:0] value;
      depth = $urandom_range(1, FRAME_HEADER_BYTES - 1);
      for (int i = 0; i < depth; i++) send_byte(scoreboard.header_pattern[8*i +: 8]);
      if ($urandom_range(0, 1) != 0) value = scoreboard.header_pattern[7:0];
      else value = 8'($urandom);
      send_byte(value);
      frame_items += depth + 1;
   endtask

   task automatic send_random_frame();
      int pick;
      int limit;
      int count;
      logic [7:0] cmd;
      limit = scoreboard.payload_limit();
      pick = $urandom_range(0, 99);
      cmd = 8'($urandom);
      if ($urandom_range(0, 14) == 0) count = $urandom_range(0, (limit < 40) ? limit : 40);
      else count = $urandom_range(0, (limit < 6) ? limit : 6);
      if (pick < 60) begin
         send_frame(cmd, count, FRAME_GOOD);
      end else if (pick < 68) begin
         send_frame(cmd, count, FRAME_BAD_SUM);
      end else if (pick < 78) begin
         send_frame(cmd, count, FRAME_BAD_TAIL);
      end else if (pick < 82) begin
         send_frame(cmd, count, FRAME_BAD_BOTH);
      end else if (pick < 87) begin
         send_frame(cmd, count, FRAME_SHORT_LENGTH);
      end else if (pick < 92) begin
         send_frame(cmd, count, FRAME_LONG_LENGTH);
      end else if (pick < 96) begin
         send_false_start();
         send_frame(cmd, count, FRAME_GOOD);
      end else begin
         repeat ($urandom_range(1, 6)) begin
            send_byte(8'($urandom));
            frame_items++;
         end
      end
   endtask

   task automatic drain_results();
      req_push <= 1'b0;
      while (scoreboard.pending() != 0) @(negedge clock);
      repeat (LATENCY_CYCLES) @(negedge clock);
   endtask

   task automatic write_csr(input csr_index_type index, input logic [31:0] value);
      csr_write_enable <= 1'b1;
      csr_index <= index;
      csr_write_data <= value;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      scoreboard.write_register(index, value);
      @(negedge clock);
   endtask

   task automatic run_phase(input int unsigned send_pct, input int unsigned recv_pct,
                            input int unsigned budget);
      bit paused;
      paused = 1'b0;
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
      frame_items = 0;
      while (frame_items < budget) begin
         send_random_frame();
         if (!paused && frame_items >= budget / 2) begin
            drain_results();
            paused = 1'b1;
         end
      end
      drain_results();
   endtask

   initial begin
      logic [7:0] repeat_byte;
      logic [7:0] other_byte;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      send_frame(8'hFF, 0, FRAME_GOOD);
      send_frame(8'h00, 0, FRAME_SHORT_LENGTH);
      send_frame(8'h00, 1, FRAME_BAD_BOTH);
      drain_results();

      write_csr(CSR_HEADER_PATTERN, $urandom);
      write_csr(CSR_TAIL_PATTERN, $urandom);
      write_csr(CSR_MAX_PAYLOAD, {24'($urandom), 8'hFF});
      write_csr(CSR_UNUSED, $urandom);
      run_phase(18, 70, 110);

      write_csr(CSR_HEADER_PATTERN, 32'hFFFF_FFFF);
      write_csr(CSR_TAIL_PATTERN, 32'h0000_FFFF);
      write_csr(CSR_MAX_PAYLOAD, 32'h0000_0000);
      run_phase(70, 18, 110);

      repeat_byte = 8'($urandom);
      other_byte = 8'($urandom);
      write_csr(CSR_HEADER_PATTERN, {repeat_byte, other_byte, repeat_byte, repeat_byte});
      write_csr(CSR_TAIL_PATTERN, 32'h0000_0000);
      write_csr(CSR_MAX_PAYLOAD, 32'd240);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      send_frame(8'($urandom), scoreboard.payload_limit(), FRAME_GOOD);
      run_phase(0, 0, 110);

      write_csr(CSR_HEADER_PATTERN, $urandom);
      write_csr(CSR_TAIL_PATTERN, $urandom);
      write_csr(CSR_MAX_PAYLOAD, $urandom_range(1, 20));
      send_frame(8'($urandom), scoreboard.payload_limit(), FRAME_GOOD);
      run_phase(0, 0, 110);

      repeat (8) @(negedge clock);
      if (scoreboard.failures == 0) begin
         $display("command_frame_deframer_tb: PASS");
      end else begin
         $display("command_frame_deframer_tb: FAIL");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("command_frame_deframer_tb: FAIL");
      $finish;
   end

endmodule
